// ===== src/atmu_pkg.sv =====
// shared types, codes and tables of the affine transform matrix unit
package atmu_pkg;

   // operation codes carried in the func field
   localparam logic [2:0] FN_IDENT  = 3'd0;
   localparam logic [2:0] FN_SCALE  = 3'd1;
   localparam logic [2:0] FN_TRANS  = 3'd2;
   localparam logic [2:0] FN_ROTATE = 3'd3;
   localparam logic [2:0] FN_XFORM  = 3'd4;
   localparam logic [2:0] FN_INV    = 3'd5;

   // vector component slots
   localparam logic [1:0] VC_X = 2'd0;
   localparam logic [1:0] VC_Y = 2'd1;
   localparam logic [1:0] VC_Z = 2'd2;
   localparam logic [1:0] VC_W = 2'd3;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] vec_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_MAC   = 3'd1,
      OP_IDENT = 3'd2,
      OP_RGEN  = 3'd3,
      OP_TGEN  = 3'd4
   } op_type;

   typedef enum logic [0:0] {
      A_MAT = 1'b0,
      A_VEC = 1'b1
   } asrc_type;

   typedef enum logic [1:0] {
      B_VEC = 2'd0,
      B_ROT = 2'd1,
      B_T   = 2'd2,
      B_ONE = 2'd3
   } bsrc_type;

   typedef enum logic [1:0] {
      D_MAT = 2'd0,
      D_ROW = 2'd1,
      D_RES = 2'd2,
      D_Q   = 2'd3
   } dst_type;

   typedef struct packed {
      logic     capture;
      logic     load_out;
      logic     out_wpass;
      op_type   op;
      asrc_type a_src;
      logic [3:0] a_idx;
      bsrc_type b_src;
      logic [3:0] b_idx;
      logic     first;
      logic     last;
      dst_type  dst;
      logic [3:0] dst_idx;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // quaternion products in order xx yy zz xy xz yz xw yw zw
   function automatic logic [1:0] quat_a(input logic [3:0] idx);
      logic [1:0] sel;
      unique case (idx)
         4'd0, 4'd3, 4'd4, 4'd6: sel = VC_X;
         4'd1, 4'd5, 4'd7:       sel = VC_Y;
         default:                sel = VC_Z;
      endcase
      return sel;
   endfunction

   function automatic logic [1:0] quat_b(input logic [3:0] idx);
      logic [1:0] sel;
      unique case (idx)
         4'd0:             sel = VC_X;
         4'd1, 4'd3:       sel = VC_Y;
         4'd2, 4'd4, 4'd5: sel = VC_Z;
         default:          sel = VC_W;
      endcase
      return sel;
   endfunction

endpackage

// ===== src/affine_transform_matrix_unit.sv =====
// top level: affine 4x4 transform unit with quaternion rotation, Q16.16 by default
// transform point and inverse transform each return a rsp beat; the matrix operations return none
// rotate forms 9 quaternion products, then 27 macs of the matrix with the rotation
// one 32x32 multiplier serves every product, one product per cycle in the mac phases, one item at a time
// a finished rsp beat waits in the output register while the next req beat is taken
// synchronous active-high reset: matrix to identity, sequencer idle, no rsp beat pending
module affine_transform_matrix_unit import atmu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: one state per phase, nested row / column / term counters
   atmu_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_payload.func),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: matrix registers, multiplier stage, accumulate/saturate stage
   atmu_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/atmu_datapath.sv =====
// matrix storage, shared multiplier, accumulator and result register
module atmu_datapath import atmu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload
);

   localparam int RND_W = 64 - FRAC_BITS;
   localparam int ACC_W = RND_W + 3;
   localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(32'sh7FFFFFFF);
   localparam logic signed [ACC_W-1:0] MINV = ACC_W'($signed(32'h80000000));

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > MAXV) r = 32'sh7FFFFFFF;
      else if (v < MINV) r = $signed(32'h80000000);
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [ACC_W-1:0] ext(input logic signed [RND_W-1:0] v);
      return ACC_W'(v);
   endfunction

   logic signed [31:0]      vec_ff [4];
   logic signed [31:0]      mat_ff [16];
   logic signed [RND_W-1:0] q_ff [9];
   logic signed [31:0]      rot_ff [9];
   logic signed [31:0]      t_ff [3];
   logic signed [31:0]      rowbuf_ff [2];
   logic signed [31:0]      res_ff [3];
   logic signed [63:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   cmd_type                 cmd_d_ff;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;

   logic signed [31:0]      op_a, op_b;
   logic signed [63:0]      rnd_sum, rnd_full;
   logic signed [RND_W-1:0] rnd;
   logic signed [ACC_W-1:0] acc_in, one_a;
   logic signed [31:0]      acc_sat;
   logic signed [31:0]      rot_in [9];
   logic signed [31:0]      t_in [3];
   logic signed [32:0]      diff [3];

   // operand select
   always_comb begin
      op_a = (cmd.a_src == A_MAT) ? mat_ff[cmd.a_idx] : vec_ff[cmd.a_idx[1:0]];
      unique case (cmd.b_src)
         B_VEC:   op_b = vec_ff[cmd.b_idx[1:0]];
         B_ROT:   op_b = rot_ff[cmd.b_idx];
         B_T:     op_b = t_ff[cmd.b_idx[1:0]];
         default: op_b = ONE;
      endcase
   end

   // round half up, then accumulate and saturate
   always_comb begin
      rnd_sum  = prod_ff + HALF;
      rnd_full = rnd_sum >>> FRAC_BITS;
      rnd      = RND_W'(rnd_full);
      acc_in   = cmd_d_ff.first ? ext(rnd) : acc_ff + ext(rnd);
      acc_sat  = sat32(acc_in);
   end

   // rotation matrix from quaternion products xx yy zz xy xz yz xw yw zw
   always_comb begin
      one_a = ACC_W'(ONE);
      rot_in[0] = sat32(one_a - (ext(q_ff[1]) <<< 1) - (ext(q_ff[2]) <<< 1));
      rot_in[1] = sat32((ext(q_ff[3]) <<< 1) - (ext(q_ff[8]) <<< 1));
      rot_in[2] = sat32((ext(q_ff[4]) <<< 1) + (ext(q_ff[7]) <<< 1));
      rot_in[3] = sat32((ext(q_ff[3]) <<< 1) + (ext(q_ff[8]) <<< 1));
      rot_in[4] = sat32(one_a - (ext(q_ff[0]) <<< 1) - (ext(q_ff[2]) <<< 1));
      rot_in[5] = sat32((ext(q_ff[5]) <<< 1) - (ext(q_ff[6]) <<< 1));
      rot_in[6] = sat32((ext(q_ff[4]) <<< 1) - (ext(q_ff[7]) <<< 1));
      rot_in[7] = sat32((ext(q_ff[5]) <<< 1) + (ext(q_ff[6]) <<< 1));
      rot_in[8] = sat32(one_a - (ext(q_ff[0]) <<< 1) - (ext(q_ff[1]) <<< 1));
   end

   // point minus translation, saturated
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         diff[r] = {vec_ff[r][31], vec_ff[r]} - {mat_ff[r*4+3][31], mat_ff[r*4+3]};
         if (diff[r][32] != diff[r][31])
            t_in[r] = diff[r][32] ? $signed(32'h80000000) : 32'sh7FFFFFFF;
         else
            t_in[r] = diff[r][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_d_ff <= '0;
      end else begin
         cmd_d_ff <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      acc_ff  <= acc_in;
      if (cmd.capture) begin
         vec_ff[0] <= req_payload.vec_x;
         vec_ff[1] <= req_payload.vec_y;
         vec_ff[2] <= req_payload.vec_z;
         vec_ff[3] <= req_payload.vec_w;
      end
      if (cmd_d_ff.op == OP_RGEN) begin
         for (int n = 0; n < 9; n++) rot_ff[n] <= rot_in[n];
      end
      if (cmd_d_ff.op == OP_TGEN) begin
         for (int n = 0; n < 3; n++) t_ff[n] <= t_in[n];
      end
      if (cmd_d_ff.op == OP_MAC && cmd_d_ff.last) begin
         unique case (cmd_d_ff.dst)
            D_ROW: if (cmd_d_ff.dst_idx[1:0] != 2'd2)
                      rowbuf_ff[cmd_d_ff.dst_idx[0]] <= acc_sat;
            D_RES: if (cmd_d_ff.dst_idx[1:0] != 2'd3)
                      res_ff[cmd_d_ff.dst_idx[1:0]] <= acc_sat;
            D_Q:   if (cmd_d_ff.dst_idx < 4'd9)
                      q_ff[cmd_d_ff.dst_idx] <= rnd;
            default: ;
         endcase
      end
   end

   // matrix, identity after reset or an identity op, else written by the macs
   always_ff @(posedge clock) begin
      if (reset || cmd_d_ff.op == OP_IDENT) begin
         for (int n = 0; n < 16; n++)
            mat_ff[n] <= (n % 5 == 0) ? ONE : 32'sd0;
      end else if (cmd_d_ff.op == OP_MAC && cmd_d_ff.last) begin
         if (cmd_d_ff.dst == D_MAT) begin
            mat_ff[cmd_d_ff.dst_idx] <= acc_sat;
         end else if (cmd_d_ff.dst == D_ROW && cmd_d_ff.dst_idx[1:0] == 2'd2) begin
            mat_ff[{cmd_d_ff.dst_idx[3:2], 2'd0}] <= rowbuf_ff[0];
            mat_ff[{cmd_d_ff.dst_idx[3:2], 2'd1}] <= rowbuf_ff[1];
            mat_ff[{cmd_d_ff.dst_idx[3:2], 2'd2}] <= acc_sat;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.out_x <= res_ff[0];
         rsp_ff.out_y <= res_ff[1];
         rsp_ff.out_z <= res_ff[2];
         rsp_ff.out_w <= cmd.out_wpass ? vec_ff[3] : 32'sd0;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

endmodule

// ===== src/atmu_controller.sv =====
// sequencer that walks each operation through the shared multiply-accumulate
module atmu_controller import atmu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_func,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_IDENT = 14'b00000000000010,
      ST_SCALE = 14'b00000000000100,
      ST_TRANS = 14'b00000000001000,
      ST_QUAT  = 14'b00000000010000,
      ST_RGEN  = 14'b00000000100000,
      ST_RBUB  = 14'b00000001000000,
      ST_ROT   = 14'b00000010000000,
      ST_XFORM = 14'b00000100000000,
      ST_TGEN  = 14'b00001000000000,
      ST_TBUB  = 14'b00010000000000,
      ST_INV   = 14'b00100000000000,
      ST_DRAIN = 14'b01000000000000,
      ST_OUT   = 14'b10000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] func_ff, func_in;
   logic [1:0] i_ff, j_ff, k_ff, i_in, j_in, k_in;
   logic [1:0] i_max, j_max, k_max;
   logic       accept, done;
   logic [3:0] qidx, ridx;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      i_max = 2'd0;
      j_max = 2'd0;
      k_max = 2'd0;
      unique case (state_ff)
         ST_SCALE: begin i_max = 2'd2; j_max = 2'd2; end
         ST_TRANS: begin i_max = 2'd2; k_max = 2'd3; end
         ST_QUAT:  begin i_max = 2'd2; j_max = 2'd2; end
         ST_ROT:   begin i_max = 2'd2; j_max = 2'd2; k_max = 2'd2; end
         ST_XFORM: begin i_max = 2'd2; k_max = 2'd3; end
         ST_INV:   begin i_max = 2'd2; k_max = 2'd2; end
         default: ;
      endcase
      done = (i_ff == i_max) && (j_ff == j_max) && (k_ff == k_max);
   end

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      if (done) begin
         i_in = 2'd0;
         j_in = 2'd0;
         k_in = 2'd0;
      end else if (k_ff != k_max) begin
         k_in = k_ff + 2'd1;
      end else if (j_ff != j_max) begin
         k_in = 2'd0;
         j_in = j_ff + 2'd1;
      end else begin
         k_in = 2'd0;
         j_in = 2'd0;
         i_in = i_ff + 2'd1;
      end
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            func_in = req_func;
            priority case (req_func)
               FN_IDENT:  state_in = ST_IDENT;
               FN_SCALE:  state_in = ST_SCALE;
               FN_TRANS:  state_in = ST_TRANS;
               FN_ROTATE: state_in = ST_QUAT;
               FN_XFORM:  state_in = ST_XFORM;
               FN_INV:    state_in = ST_TGEN;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_IDENT, ST_SCALE, ST_TRANS, ST_ROT, ST_XFORM, ST_INV:
            if (done) state_in = ST_DRAIN;
         ST_QUAT:  if (done) state_in = ST_RGEN;
         ST_RGEN:  state_in = ST_RBUB;
         ST_RBUB:  state_in = ST_ROT;
         ST_TGEN:  state_in = ST_TBUB;
         ST_TBUB:  state_in = ST_INV;
         ST_DRAIN: state_in = (func_ff == FN_XFORM || func_ff == FN_INV) ? ST_OUT : ST_IDLE;
         ST_OUT:   if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         func_ff  <= FN_IDENT;
         i_ff     <= 2'd0;
         j_ff     <= 2'd0;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         func_ff  <= func_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // index = 3*row + col for the quaternion and rotation tables
   assign qidx = {1'b0, i_ff, 1'b0} + {2'b0, i_ff} + {2'b0, j_ff};
   assign ridx = {1'b0, k_ff, 1'b0} + {2'b0, k_ff} + {2'b0, j_ff};

   always_comb begin
      cmd           = '0;
      cmd.capture   = accept;
      cmd.op        = OP_NONE;
      cmd.a_src     = A_MAT;
      cmd.b_src     = B_VEC;
      cmd.dst       = D_MAT;
      cmd.out_wpass = (func_ff == FN_XFORM);
      unique case (state_ff)
         ST_IDENT: cmd.op = OP_IDENT;
         ST_RGEN:  cmd.op = OP_RGEN;
         ST_TGEN:  cmd.op = OP_TGEN;
         ST_SCALE: begin
            cmd.op      = OP_MAC;
            cmd.a_idx   = {i_ff, j_ff};
            cmd.b_idx   = {2'b0, j_ff};
            cmd.first   = 1'b1;
            cmd.last    = 1'b1;
            cmd.dst_idx = {i_ff, j_ff};
         end
         ST_TRANS: begin
            cmd.op      = OP_MAC;
            cmd.a_idx   = {i_ff, k_ff};
            cmd.b_src   = (k_ff == 2'd3) ? B_ONE : B_VEC;
            cmd.b_idx   = {2'b0, k_ff};
            cmd.first   = (k_ff == 2'd0);
            cmd.last    = (k_ff == 2'd3);
            cmd.dst_idx = {i_ff, 2'd3};
         end
         ST_QUAT: begin
            cmd.op      = OP_MAC;
            cmd.a_src   = A_VEC;
            cmd.a_idx   = {2'b0, quat_a(qidx)};
            cmd.b_idx   = {2'b0, quat_b(qidx)};
            cmd.first   = 1'b1;
            cmd.last    = 1'b1;
            cmd.dst     = D_Q;
            cmd.dst_idx = qidx;
         end
         ST_ROT: begin
            cmd.op      = OP_MAC;
            cmd.a_idx   = {i_ff, k_ff};
            cmd.b_src   = B_ROT;
            cmd.b_idx   = ridx;
            cmd.first   = (k_ff == 2'd0);
            cmd.last    = (k_ff == 2'd2);
            cmd.dst     = D_ROW;
            cmd.dst_idx = {i_ff, j_ff};
         end
         ST_XFORM: begin
            cmd.op      = OP_MAC;
            cmd.a_idx   = {i_ff, k_ff};
            cmd.b_idx   = {2'b0, k_ff};
            cmd.first   = (k_ff == 2'd0);
            cmd.last    = (k_ff == 2'd3);
            cmd.dst     = D_RES;
            cmd.dst_idx = {2'b0, i_ff};
         end
         ST_INV: begin
            cmd.op      = OP_MAC;
            cmd.a_idx   = {k_ff, i_ff};
            cmd.b_src   = B_T;
            cmd.b_idx   = {2'b0, k_ff};
            cmd.first   = (k_ff == 2'd0);
            cmd.last    = (k_ff == 2'd2);
            cmd.dst     = D_RES;
            cmd.dst_idx = {2'b0, i_ff};
         end
         ST_OUT:  cmd.load_out = status.out_free;
         default: ;
      endcase
   end

endmodule

// ===== src/atmu_checker.sv =====
// port-level checker for the affine transform matrix unit and its bind
module atmu_checker import atmu_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // no rsp beat right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a held rsp beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat dropped or changed while stalled");

   // a valid operation keeps the unit busy the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.func <= FN_INV) |=> req_stall)
      else $error("req not stalled while operation runs");

   // a new rsp beat is only loaded while the request side is held off
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> $past(req_stall))
      else $error("rsp beat appeared while idle");

endmodule

bind affine_transform_matrix_unit atmu_checker u_chk (.*);

// ===== verif/affine_transform_matrix_unit_checker.sv =====
// checker for the affine transform matrix unit: predicts each response beat and compares it
`timescale 1ns / 100ps
module affine_transform_matrix_unit_checker import atmu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending
);

   logic signed [31:0] mat [16];
   rsp_type point_q[$];

   function automatic logic signed [63:0] rmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + (64'sd1 <<< (FRAC_BITS - 1));
      return p >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] clip(input logic signed [63:0] v);
      if (v > 64'sh7fffffff) return 32'sh7fffffff;
      if (v < -64'sh80000000) return -32'sh80000000;
      return v[31:0];
   endfunction

   function automatic void load_ident();
      for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
   endfunction

   function automatic void apply_beat(input req_type b);
      logic signed [31:0] v [4];
      logic signed [31:0] rot [16];
      logic signed [31:0] nxt [16];
      logic signed [31:0] t [3];
      logic signed [63:0] acc, one, xx, yy, zz, xy, xz, yz, xw, yw, zw;
      rsp_type res;
      v[0] = b.vec_x; v[1] = b.vec_y; v[2] = b.vec_z; v[3] = b.vec_w;
      one = 64'sd1 <<< FRAC_BITS;
      res = '0;
      case (b.func)
         FN_IDENT: load_ident();
         FN_SCALE:
            for (int r = 0; r < 3; r++)
               for (int c = 0; c < 3; c++) mat[r*4+c] = clip(rmul(mat[r*4+c], v[c]));
         FN_TRANS:
            for (int r = 0; r < 3; r++) begin
               acc = 64'(mat[r*4+3]);
               for (int c = 0; c < 3; c++) acc += rmul(mat[r*4+c], v[c]);
               mat[r*4+3] = clip(acc);
            end
         FN_ROTATE: begin
            xx = rmul(v[0], v[0]); yy = rmul(v[1], v[1]); zz = rmul(v[2], v[2]);
            xy = rmul(v[0], v[1]); xz = rmul(v[0], v[2]); yz = rmul(v[1], v[2]);
            xw = rmul(v[0], v[3]); yw = rmul(v[1], v[3]); zw = rmul(v[2], v[3]);
            for (int i = 0; i < 16; i++) rot[i] = (i % 5 == 0) ? one[31:0] : 32'sd0;
            rot[0]  = clip(one - 2*yy - 2*zz);
            rot[1]  = clip(2*xy - 2*zw);
            rot[2]  = clip(2*xz + 2*yw);
            rot[4]  = clip(2*xy + 2*zw);
            rot[5]  = clip(one - 2*xx - 2*zz);
            rot[6]  = clip(2*yz - 2*xw);
            rot[8]  = clip(2*xz - 2*yw);
            rot[9]  = clip(2*yz + 2*xw);
            rot[10] = clip(one - 2*xx - 2*yy);
            for (int i = 0; i < 4; i++)
               for (int j = 0; j < 4; j++) begin
                  acc = 0;
                  for (int k = 0; k < 4; k++) acc += rmul(mat[i*4+k], rot[k*4+j]);
                  nxt[i*4+j] = clip(acc);
               end
            mat = nxt;
         end
         FN_XFORM: begin
            for (int r = 0; r < 3; r++) begin
               acc = 0;
               for (int c = 0; c < 4; c++) acc += rmul(mat[r*4+c], v[c]);
               t[r] = clip(acc);
            end
            res.out_x = t[0]; res.out_y = t[1]; res.out_z = t[2]; res.out_w = v[3];
            point_q.push_back(res);
         end
         FN_INV: begin
            for (int r = 0; r < 3; r++) t[r] = clip(64'(v[r]) - 64'(mat[r*4+3]));
            for (int c = 0; c < 3; c++) begin
               acc = 0;
               for (int r = 0; r < 3; r++) acc += rmul(mat[r*4+c], t[r]);
               v[c] = clip(acc);
            end
            res.out_x = v[0]; res.out_y = v[1]; res.out_z = v[2]; res.out_w = '0;
            point_q.push_back(res);
         end
         default: ;
      endcase
   endfunction

   assign pending = point_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         load_ident();
         point_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (point_q.size() == 0) begin
               $display("%0t: unexpected rsp beat %h", $time, rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = point_q.pop_front();
               if (rsp_payload !== want) begin
                  $display("%0t: rsp mismatch expected x=%h y=%h z=%h w=%h actual x=%h y=%h z=%h w=%h",
                           $time, want.out_x, want.out_y, want.out_z, want.out_w,
                           rsp_payload.out_x, rsp_payload.out_y, rsp_payload.out_z,
                           rsp_payload.out_w);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) apply_beat(req_payload);
      end
   end

   initial fail_count = 0;

endmodule

// ===== verif/affine_transform_matrix_unit_tb.sv =====
// testbench top for the affine transform matrix unit: stimulus, clock, reset and verdict
`timescale 1ns / 100ps
module affine_transform_matrix_unit_tb;
   import atmu_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending;
   bit      calm;        // no idling on either side while set
   bit      drive_done;

   affine_transform_matrix_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   affine_transform_matrix_unit_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response side stalls about a third of the time except in the calm stretch
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !calm && ($urandom_range(99) < 32);
   end

   // random component: mostly modest Q16.16 values, sometimes any 32-bit pattern
   function automatic logic [31:0] pick_comp();
      case ($urandom_range(9))
         0, 1:    return $urandom();
         2:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         3:       return 32'h0;
         default: return $signed($urandom_range(32'h40000)) - 32'sh20000;
      endcase
   endfunction

   // small quaternion so rotations stay near unit scale
   function automatic logic [31:0] pick_quat();
      return $signed($urandom_range(32'h20000)) - 32'sh10000;
   endfunction

   // hold a beat until it is taken; optional idle cycles in front of it
   task automatic send_beat(input logic [2:0] fn, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] w);
      while (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{func: fn, vec_x: x, vec_y: y, vec_z: z, vec_w: w};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drawn beat: point transforms dominate, matrix ops keep the state moving
   task automatic send_random();
      int sel;
      logic [2:0] fn;
      sel = $urandom_range(99);
      if (sel < 35)      fn = FN_XFORM;
      else if (sel < 60) fn = FN_INV;
      else if (sel < 70) fn = FN_SCALE;
      else if (sel < 80) fn = FN_TRANS;
      else if (sel < 90) fn = FN_ROTATE;
      else if (sel < 96) fn = FN_IDENT;
      else               fn = 3'($urandom_range(7, 6));  // unused codes
      if (fn == FN_ROTATE && $urandom_range(3) != 0)
         send_beat(fn, pick_quat(), pick_quat(), pick_quat(), pick_quat());
      else if (fn == FN_SCALE && $urandom_range(3) != 0)
         send_beat(fn, pick_quat() + 32'h10000, pick_quat() + 32'h10000,
                   pick_quat() + 32'h10000, $urandom());
      else
         send_beat(fn, pick_comp(), pick_comp(), pick_comp(), pick_comp());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      calm = 1'b0;
      drive_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: identity point, extremes, every op, unused codes, ignored w
      send_beat(FN_XFORM, 32'h10000, 32'h20000, 32'hfffd0000, 32'h10000);
      send_beat(FN_XFORM, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h80000000);
      send_beat(FN_INV, 32'h80000000, 32'h7fffffff, 32'h1, 32'h7fffffff);
      send_beat(FN_SCALE, 32'h20000, 32'h8000, 32'hffff0000, 32'h12345678);
      send_beat(FN_XFORM, 32'h30000, 32'h30000, 32'h30000, 32'h10000);
      send_beat(FN_TRANS, 32'h50000, 32'hfffb0000, 32'h7fffffff, 32'hdeadbeef);
      send_beat(FN_XFORM, 32'h0, 32'h0, 32'h0, 32'h10000);
      send_beat(FN_INV, 32'h0, 32'h0, 32'h0, 32'hffffffff);
      send_beat(3'd6, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_beat(3'd7, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_beat(FN_ROTATE, 32'h0, 32'h0, 32'hb505, 32'hb505);
      send_beat(FN_XFORM, 32'h10000, 32'h0, 32'h0, 32'h10000);
      send_beat(FN_INV, 32'h10000, 32'h10000, 32'h10000, 32'h0);
      send_beat(FN_ROTATE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send_beat(FN_XFORM, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
      send_beat(FN_INV, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0);
      send_beat(FN_IDENT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_beat(FN_XFORM, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
      // random part with a calm stretch in the middle
      for (int n = 0; n < 1550; n++) begin
         calm = (n >= 600 && n < 800);
         send_random();
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      drive_done = 1'b1;
   end

   initial begin
      wait (drive_done);
      // let the checker see the last req beat before looking at the backlog
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // worst case ~1600 beats, each with its busy time and long idles, is well under this
   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== affine_transform_matrix_unit.f =====
src/atmu_pkg.sv
src/atmu_datapath.sv
src/atmu_controller.sv
src/affine_transform_matrix_unit.sv
src/atmu_checker.sv
verif/affine_transform_matrix_unit_checker.sv
verif/affine_transform_matrix_unit_tb.sv
